// ===== hw/rtl/g711c_pkg.sv =====
// Shared types, constants and helper functions for the G.711 codec unit.
// Used by g711c_pipe_ctl and g711_alaw_ulaw_codec_unit; no dependencies.
package g711c_pkg;

   typedef struct packed {
      logic signed [15:0] pcm_in;
      logic [7:0]         code_in;
   } req_type;

   typedef struct packed {
      logic [7:0]         code_out;
      logic signed [15:0] pcm_out;
   } rsp_type;

   localparam int unsigned NUM_STAGES = 3;

   typedef struct packed {
      logic [NUM_STAGES-1:0] valid;
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

   typedef struct packed {
      logic        dec;
      logic        mu;
      logic        neg;
      logic [14:0] mag;
      logic [7:0]  mask;
      logic [2:0]  seg;
      logic [3:0]  shamt;
   } stage_type;

   localparam logic [7:0]  ALAW_MASK_POS = 8'hD5;
   localparam logic [7:0]  ALAW_MASK_NEG = 8'h55;
   localparam logic [7:0]  MU_MASK_POS   = 8'hFF;
   localparam logic [7:0]  MU_MASK_NEG   = 8'h7F;
   localparam logic [15:0] MU_CLIP       = 16'd32635;
   localparam logic [15:0] MU_BIAS       = 16'h0084;
   localparam logic [8:0]  ALAW_SEG0_ADD = 9'h008;
   localparam logic [8:0]  ALAW_SEGN_ADD = 9'h108;

   localparam logic [14:0] SEG_LIMIT [8] = '{
      15'h00FF, 15'h01FF, 15'h03FF, 15'h07FF,
      15'h0FFF, 15'h1FFF, 15'h3FFF, 15'h7FFF
   };

   // Segment of a magnitude: number of segment end points below it.
   // Mu-law segments start one end point higher than A-law segments.
   function automatic logic [2:0] find_seg(input logic [14:0] mag, input logic mu);
      logic [2:0] seg;
      seg = 3'd0;
      for (int s = 0; s < 7; s++) begin
         if (mu) begin
            if (mag > SEG_LIMIT[s+1]) seg = 3'(s + 1);
         end else begin
            if (mag > SEG_LIMIT[s]) seg = 3'(s + 1);
         end
      end
      return seg;
   endfunction

endpackage

// ===== hw/rtl/g711c_pipe_ctl.sv =====
// Valid and load control for the three-stage codec pipeline.
// Depends on g711c_pkg for the control struct.
module g711c_pipe_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   rsp_stall,
   output g711c_pkg::pipe_ctl_type ctl
);
   import g711c_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[0];
   assign ctl.valid = valid_ff;
   assign ctl.load  = load;

`ifndef SYNTH
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && rsp_stall) |-> req_stall)
      else $error("full pipeline did not stall the input");
   a_empty_take: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> !req_stall)
      else $error("empty first stage refused a transfer");
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[1] && !load[1]) |=> valid_ff[1])
      else $error("stalled middle stage lost its item");
   a_out_move: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[1] && !rsp_stall) |=> valid_ff[2])
      else $error("middle stage item did not reach the output");
`endif

endmodule

// ===== hw/rtl/g711_alaw_ulaw_codec_unit.sv =====
// G.711 A-law and mu-law encoder and decoder, three-stage pipeline.
// Depends on g711c_pkg and g711c_pipe_ctl.
//
// Usage: the req_ channel carries a PCM sample and a code byte; one is used
// depending on the direction register. The rsp_ channel returns one result
// per transfer: code_out when encoding, pcm_out when decoding, with the
// other field zero. A transfer happens on a rising edge with valid high and
// stall low on that channel.
// The csr_ port writes law_select (index 0) and direction (index 1); only
// bit 0 of the data is kept. Write it only while no result is outstanding.
// From input transfer to rsp_valid the stages are magnitude and mask, then
// segment search or expansion shift, then mantissa and sign. Throughput is one
// item per cycle while rsp_stall is low. When it is high, items stay in
// their stages and fill the empty ones; req_stall rises only once all three
// stages hold an item. Reset empties the pipeline and selects A-law encode.
module g711_alaw_ulaw_codec_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  g711c_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output g711c_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic               csr_wdata
);
   import g711c_pkg::*;

   localparam logic CSR_LAW_SELECT = 1'b0;
   localparam logic CSR_DIRECTION  = 1'b1;

   pipe_ctl_type ctl;
   logic         law_ff, law_in;
   logic         dir_ff, dir_in;
   stage_type    s1_ff, s1_in;
   stage_type    s2_ff, s2_in;
   rsp_type      s3_ff, s3_in;

   logic [16:0] pcm_ext, neg_pcm, a_neg;
   logic [15:0] mu_abs, mu_clip;
   logic        sign;
   logic [7:0]  v;
   logic [14:0] shifted;
   logic [7:0]  code;
   logic [15:0] dval;

   g711c_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   always_comb begin
      law_in = law_ff;
      dir_in = dir_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LAW_SELECT: law_in = csr_wdata;
            CSR_DIRECTION:  dir_in = csr_wdata;
            default:        law_in = law_ff;
         endcase
      end
   end

   always_comb begin
      pcm_ext = {req_data.pcm_in[15], req_data.pcm_in};
      neg_pcm = 17'd0 - pcm_ext;
      a_neg   = neg_pcm - 17'd8;
      sign    = req_data.pcm_in[15];
      mu_abs  = sign ? neg_pcm[15:0] : {1'b0, req_data.pcm_in[14:0]};
      mu_clip = (mu_abs > MU_CLIP) ? MU_CLIP : mu_abs;
      v       = law_ff ? ~req_data.code_in : (req_data.code_in ^ ALAW_MASK_NEG);

      s1_in       = '0;
      s1_in.dec   = dir_ff;
      s1_in.mu    = law_ff;
      if (!dir_ff) begin
         if (law_ff) begin
            s1_in.neg  = sign;
            s1_in.mag  = 15'(mu_clip + MU_BIAS);
            s1_in.mask = sign ? MU_MASK_NEG : MU_MASK_POS;
         end else begin
            s1_in.neg  = sign;
            s1_in.mag  = sign ? (a_neg[16] ? 15'd0 : a_neg[14:0]) : req_data.pcm_in[14:0];
            s1_in.mask = sign ? ALAW_MASK_NEG : ALAW_MASK_POS;
         end
      end else begin
         s1_in.seg = v[6:4];
         if (law_ff) begin
            s1_in.neg   = v[7];
            s1_in.mag   = 15'({v[3:0], 3'b000}) + 15'(MU_BIAS);
            s1_in.shamt = {1'b0, v[6:4]};
         end else begin
            s1_in.neg   = !v[7];
            s1_in.mag   = 15'({v[3:0], 4'b0000})
                        + 15'((v[6:4] == 3'd0) ? ALAW_SEG0_ADD : ALAW_SEGN_ADD);
            s1_in.shamt = (v[6:4] > 3'd1) ? {1'b0, v[6:4] - 3'd1} : 4'd0;
         end
      end
   end

   always_comb begin
      s2_in = s1_ff;
      if (!s1_ff.dec) begin
         s2_in.seg = find_seg(s1_ff.mag, s1_ff.mu);
         if (!s1_ff.mu && s2_in.seg < 3'd2) begin
            s2_in.shamt = 4'd4;
         end else begin
            s2_in.shamt = {1'b0, s2_in.seg} + 4'd3;
         end
      end else begin
         s2_in.mag = s1_ff.mag << s1_ff.shamt;
      end
   end

   always_comb begin
      shifted = s2_ff.mag >> s2_ff.shamt;
      code    = {1'b0, s2_ff.seg, shifted[3:0]};
      dval    = {1'b0, s2_ff.mag} - (s2_ff.mu ? MU_BIAS : 16'd0);
      s3_in   = '0;
      if (!s2_ff.dec) begin
         s3_in.code_out = s2_ff.mu ? (~code & s2_ff.mask) : (code ^ s2_ff.mask);
      end else begin
         s3_in.pcm_out = s2_ff.neg ? -$signed(dval) : $signed(dval);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         law_ff <= 1'b0;
         dir_ff <= 1'b0;
      end else begin
         law_ff <= law_in;
         dir_ff <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) s1_ff <= s1_in;
      if (ctl.load[1]) s2_ff <= s2_in;
      if (ctl.load[2]) s3_ff <= s3_in;
   end

   assign rsp_valid = ctl.valid[2];
   assign rsp_data  = s3_ff;

endmodule
